/* design/cgpp_pkg.sv */
`default_nettype none
package cgpp_pkg;

	localparam int ACT_W   = 2;
	localparam int DRAW_W  = 15;
	localparam int COORD_W = 18;
	localparam int FRAC_W  = 8;
	localparam int PIX_W   = 10;
	localparam int RULE_W  = 2;

	// action codes on the input channel
	localparam logic [ACT_W-1:0] ACT_APPEND = 2'd0;
	localparam logic [ACT_W-1:0] ACT_MARKER = 2'd1;
	localparam logic [ACT_W-1:0] ACT_TICK   = 2'd2;

	// rule_mode codes
	localparam logic [RULE_W-1:0] RULE_ANY         = 2'd0;
	localparam logic [RULE_W-1:0] RULE_NO_REPEAT   = 2'd1;
	localparam logic [RULE_W-1:0] RULE_NO_NEIGHBOR = 2'd2;
	localparam logic [RULE_W-1:0] RULE_NO_SECOND   = 2'd3;

	localparam int MIN_ANCHORS = 3;
	localparam int Q_DEPTH     = 2;

	typedef enum logic [1:0] {
		OP_APPEND,
		OP_MARKER,
		OP_TICK
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [DRAW_W-1:0]  draw;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic rem_ok;
		logic last_ok;
	} back_status_t;

endpackage
`default_nettype wire

/* design/cgpp_front.sv */
`default_nettype none
module cgpp_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [cgpp_pkg::ACT_W-1:0]    action,
	input  wire logic [cgpp_pkg::DRAW_W-1:0]   random_draw,
	input  wire logic [cgpp_pkg::COORD_W-1:0]  coord_x,
	input  wire logic [cgpp_pkg::COORD_W-1:0]  coord_y,
	input  wire logic                          q_full,
	output logic                               q_push,
	output cgpp_pkg::cmd_t                     q_cmd
);

	logic           v_s1;
	cgpp_pkg::cmd_t cmd_s1;
	logic           keep;
	cgpp_pkg::op_t  op;
	logic           accept;

	always_comb begin
		keep = 1'b1;
		op   = cgpp_pkg::OP_APPEND;
		unique case (action)
			cgpp_pkg::ACT_APPEND: op = cgpp_pkg::OP_APPEND;
			cgpp_pkg::ACT_MARKER: op = cgpp_pkg::OP_MARKER;
			cgpp_pkg::ACT_TICK:   op = cgpp_pkg::OP_TICK;
			default:              keep = 1'b0;
		endcase
	end

	assign in_stall = v_s1 && q_full;
	assign accept   = in_valid && !in_stall;
	assign q_push   = v_s1 && !q_full;
	assign q_cmd    = cmd_s1;

	// unused action codes are taken and dropped here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= keep;
		end else if (q_push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1.op   <= op;
			cmd_s1.draw <= random_draw;
			cmd_s1.x    <= coord_x;
			cmd_s1.y    <= coord_y;
		end
	end

endmodule
`default_nettype wire

/* design/cgpp_queue.sv */
`default_nettype none
module cgpp_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire cgpp_pkg::cmd_t push_cmd,
	output logic                full,
	input  wire logic           pop,
	output logic                pop_valid,
	output cgpp_pkg::cmd_t      pop_cmd
);

	localparam int AW = $clog2(cgpp_pkg::Q_DEPTH);

	cgpp_pkg::cmd_t  slot_q [cgpp_pkg::Q_DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [AW:0]     level_q;
	logic            do_push;
	logic            do_pop;

	assign full      = (level_q == (AW+1)'(cgpp_pkg::Q_DEPTH));
	assign pop_valid = (level_q != '0);
	assign pop_cmd   = slot_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + AW'(1);
			if (do_pop)  rd_ptr_q <= rd_ptr_q + AW'(1);
			if (do_push && !do_pop) level_q <= level_q + (AW+1)'(1);
			else if (do_pop && !do_push) level_q <= level_q - (AW+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= push_cmd;
	end

endmodule
`default_nettype wire

/* design/cgpp_back.sv */
`default_nettype none
module cgpp_back #(
	parameter int MAX_ANCHORS   = 8,
	parameter int DOT_RADIUS    = 2,
	parameter int SCREEN_WIDTH  = 1024,
	parameter int SCREEN_HEIGHT = 1024
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [cgpp_pkg::RULE_W-1:0]   cfg_wdata,
	input  wire logic                          q_valid,
	input  wire cgpp_pkg::cmd_t                q_cmd,
	output logic                               q_pop,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [cgpp_pkg::PIX_W-1:0]         pixel_x,
	output logic [cgpp_pkg::PIX_W-1:0]         pixel_y,
	output logic                               last_pixel,
	output cgpp_pkg::back_status_t             status
);

	localparam int CNT_W  = $clog2(MAX_ANCHORS + 1);
	localparam int IDX_W  = $clog2(MAX_ANCHORS);
	localparam int D_W    = $clog2(DOT_RADIUS + 1) + 1;
	localparam int SQ_W   = 2 * D_W + 1;
	localparam int PX_W   = cgpp_pkg::PIX_W + 2;
	localparam int STEP_W = $clog2(cgpp_pkg::DRAW_W);
	localparam int CW     = cgpp_pkg::COORD_W;

	localparam logic signed [D_W-1:0]  R_S  = D_W'(DOT_RADIUS);
	localparam logic signed [SQ_W-1:0] RR_S = SQ_W'(DOT_RADIUS * DOT_RADIUS);
	localparam logic signed [PX_W-1:0] SW_S = PX_W'(SCREEN_WIDTH);
	localparam logic signed [PX_W-1:0] SH_S = PX_W'(SCREEN_HEIGHT);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD,
		ST_MOVE,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	state_t                          state_q;
	logic [cgpp_pkg::RULE_W-1:0]     rule_q;
	logic [CNT_W-1:0]                count_q;
	logic [IDX_W-1:0]                last_q;
	logic [CW-1:0]                   mx_q;
	logic [CW-1:0]                   my_q;
	logic [CW-1:0]                   ax_q [MAX_ANCHORS];
	logic [CW-1:0]                   ay_q [MAX_ANCHORS];
	logic [cgpp_pkg::DRAW_W-1:0]     draw_q;
	logic [CNT_W-1:0]                rem_q;
	logic [STEP_W-1:0]               step_q;
	logic signed [D_W-1:0]           dx_q;
	logic signed [D_W-1:0]           dy_q;
	logic                            pend_v_q;
	logic [cgpp_pkg::PIX_W-1:0]      pend_x_q;
	logic [cgpp_pkg::PIX_W-1:0]      pend_y_q;
	logic                            out_valid_q;
	logic [cgpp_pkg::PIX_W-1:0]      pixel_x_q;
	logic [cgpp_pkg::PIX_W-1:0]      pixel_y_q;
	logic                            last_q_out;

	logic                            append_ok;
	logic [CNT_W:0]                  rem_t;
	logic [CNT_W:0]                  rem_sub;
	logic [CNT_W-1:0]                rem_next;
	logic [IDX_W-1:0]                cand;
	logic [IDX_W-1:0]                idx_gap;
	logic                            allowed;
	logic [CW:0]                     sum_x;
	logic [CW:0]                     sum_y;
	logic signed [SQ_W-1:0]          dxe;
	logic signed [SQ_W-1:0]          dye;
	logic signed [SQ_W-1:0]          dsq;
	logic signed [PX_W-1:0]          px;
	logic signed [PX_W-1:0]          py;
	logic                            hit;
	logic                            out_free;
	logic                            scan_hold;
	logic                            scan_end;
	logic                            out_load;

	assign q_pop      = (state_q == ST_IDLE) && q_valid;
	assign out_valid  = out_valid_q;
	assign pixel_x    = pixel_x_q;
	assign pixel_y    = pixel_y_q;
	assign last_pixel = last_q_out;
	assign out_free   = !out_valid_q || !out_stall;

	assign append_ok = (count_q < CNT_W'(MAX_ANCHORS));

	// one restoring step of draw modulo count per cycle
	assign rem_t    = {rem_q, draw_q[cgpp_pkg::DRAW_W-1]};
	assign rem_sub  = rem_t - {1'b0, count_q};
	assign rem_next = (rem_t >= {1'b0, count_q}) ? rem_sub[CNT_W-1:0] : rem_t[CNT_W-1:0];

	assign cand    = rem_q[IDX_W-1:0];
	assign idx_gap = (cand > last_q) ? (cand - last_q) : (last_q - cand);

	always_comb begin
		allowed = 1'b1;
		unique case (rule_q)
			cgpp_pkg::RULE_ANY:         allowed = 1'b1;
			cgpp_pkg::RULE_NO_REPEAT:   allowed = (idx_gap != '0);
			cgpp_pkg::RULE_NO_NEIGHBOR: allowed = (idx_gap != IDX_W'(1));
			cgpp_pkg::RULE_NO_SECOND:   allowed = (idx_gap != IDX_W'(2));
			default:                    allowed = 1'b1;
		endcase
	end

	assign sum_x = {1'b0, ax_q[cand]} + {1'b0, mx_q};
	assign sum_y = {1'b0, ay_q[cand]} + {1'b0, my_q};

	assign dxe = SQ_W'(dx_q);
	assign dye = SQ_W'(dy_q);
	assign dsq = dxe * dxe + dye * dye;
	assign px  = $signed({2'b00, mx_q[CW-1:cgpp_pkg::FRAC_W]}) + PX_W'(dx_q);
	assign py  = $signed({2'b00, my_q[CW-1:cgpp_pkg::FRAC_W]}) + PX_W'(dy_q);
	assign hit = (dsq <= RR_S) && !px[PX_W-1] && (px < SW_S) && !py[PX_W-1] && (py < SH_S);

	// a found pixel waits in the pending slot until the next one shows it is not the last
	assign scan_hold = hit && pend_v_q && !out_free;
	assign scan_end  = (dx_q == R_S) && (dy_q == R_S);
	assign out_load  = (state_q == ST_SCAN && !scan_hold && hit && pend_v_q) ||
	                   (state_q == ST_FLUSH && pend_v_q && out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rule_q      <= cgpp_pkg::RULE_ANY;
			count_q     <= '0;
			last_q      <= '0;
			mx_q        <= '0;
			my_q        <= '0;
			draw_q      <= '0;
			rem_q       <= '0;
			step_q      <= '0;
			dx_q        <= '0;
			dy_q        <= '0;
			pend_v_q    <= 1'b0;
			pend_x_q    <= '0;
			pend_y_q    <= '0;
			pixel_x_q   <= '0;
			pixel_y_q   <= '0;
			last_q_out  <= 1'b0;
		end else begin
			if (cfg_we) rule_q <= cfg_wdata;

			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						unique case (q_cmd.op)
							cgpp_pkg::OP_APPEND: begin
								if (append_ok) count_q <= count_q + CNT_W'(1);
							end
							cgpp_pkg::OP_MARKER: begin
								mx_q <= q_cmd.x;
								my_q <= q_cmd.y;
							end
							cgpp_pkg::OP_TICK: begin
								if (count_q >= CNT_W'(cgpp_pkg::MIN_ANCHORS)) begin
									draw_q  <= q_cmd.draw;
									rem_q   <= '0;
									step_q  <= STEP_W'(cgpp_pkg::DRAW_W - 1);
									state_q <= ST_MOD;
								end
							end
							default: ;
						endcase
					end
				end
				ST_MOD: begin
					rem_q  <= rem_next;
					draw_q <= {draw_q[cgpp_pkg::DRAW_W-2:0], 1'b0};
					step_q <= step_q - STEP_W'(1);
					if (step_q == '0) state_q <= ST_MOVE;
				end
				ST_MOVE: begin
					if (allowed) begin
						last_q   <= cand;
						mx_q     <= sum_x[CW:1];
						my_q     <= sum_y[CW:1];
						dx_q     <= -R_S;
						dy_q     <= -R_S;
						pend_v_q <= 1'b0;
						state_q  <= ST_SCAN;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					if (!scan_hold) begin
						if (hit) begin
							pend_v_q <= 1'b1;
							pend_x_q <= px[cgpp_pkg::PIX_W-1:0];
							pend_y_q <= py[cgpp_pkg::PIX_W-1:0];
							if (pend_v_q) begin
								pixel_x_q   <= pend_x_q;
								pixel_y_q   <= pend_y_q;
								last_q_out  <= 1'b0;
							end
						end
						if (scan_end) begin
							state_q <= ST_FLUSH;
						end else if (dy_q == R_S) begin
							dy_q <= -R_S;
							dx_q <= dx_q + D_W'(1);
						end else begin
							dy_q <= dy_q + D_W'(1);
						end
					end
				end
				ST_FLUSH: begin
					if (!pend_v_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						pixel_x_q   <= pend_x_q;
						pixel_y_q   <= pend_y_q;
						last_q_out  <= 1'b1;
						pend_v_q    <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// anchor table, entries above the fill count are never read
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_valid && q_cmd.op == cgpp_pkg::OP_APPEND && append_ok) begin
			ax_q[count_q[IDX_W-1:0]] <= q_cmd.x;
			ay_q[count_q[IDX_W-1:0]] <= q_cmd.y;
		end
	end

	assign status.busy    = (state_q != ST_IDLE);
	assign status.rem_ok  = (state_q != ST_MOD && state_q != ST_MOVE) || (rem_q < count_q);
	assign status.last_ok = (count_q == '0) || (CNT_W'(last_q) < count_q);

endmodule
`default_nettype wire

/* design/chaos_game_point_plotter_top.sv */
`default_nettype none
// Chaos-game point plotter. Appends (action 0) and marker writes (action 1) are handled in
// the back end's idle state as they are popped; action 3 is dropped at the front. A draw tick
// (action 2) with at least three anchors is dequeued, then runs the bit-serial draw modulo
// anchor count, the rule check and midpoint, the (2*DOT_RADIUS+1)^2-point disc scan and a
// flush; a tick the rule rejects ends after the rule check. Scan and flush wait while out_stall
// holds the output register. A two-entry command queue sits between the input stage and the
// back end, so new transactions are taken while a disc is drawn until the queue and stage fill.
// The user writes rule_mode via cfg_we/cfg_wdata only while the block is idle (not enforced).
module chaos_game_point_plotter_top #(
	parameter int MAX_ANCHORS   = 8,
	parameter int DOT_RADIUS    = 2,
	parameter int SCREEN_WIDTH  = 1024,
	parameter int SCREEN_HEIGHT = 1024
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [cgpp_pkg::RULE_W-1:0]   cfg_wdata,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [cgpp_pkg::ACT_W-1:0]    action,
	input  wire logic [cgpp_pkg::DRAW_W-1:0]   random_draw,
	input  wire logic [cgpp_pkg::COORD_W-1:0]  coord_x,
	input  wire logic [cgpp_pkg::COORD_W-1:0]  coord_y,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [cgpp_pkg::PIX_W-1:0]         pixel_x,
	output logic [cgpp_pkg::PIX_W-1:0]         pixel_y,
	output logic                               last_pixel
);

	logic                     q_push;
	logic                     q_full;
	cgpp_pkg::cmd_t           q_in_cmd;
	logic                     q_pop;
	logic                     q_valid;
	cgpp_pkg::cmd_t           q_out_cmd;
	cgpp_pkg::back_status_t   back_st;

	cgpp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.random_draw (random_draw),
		.coord_x     (coord_x),
		.coord_y     (coord_y),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_cmd       (q_in_cmd)
	);

	cgpp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (q_in_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.pop_valid (q_valid),
		.pop_cmd   (q_out_cmd)
	);

	cgpp_back #(
		.MAX_ANCHORS   (MAX_ANCHORS),
		.DOT_RADIUS    (DOT_RADIUS),
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.q_valid    (q_valid),
		.q_cmd      (q_out_cmd),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.last_pixel (last_pixel),
		.status     (back_st)
	);

	// the back end takes no new transaction while a tick is in flight
	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		back_st.busy |-> !q_pop)
		else $error("queue popped while back end busy");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		back_st.rem_ok)
		else $error("modulo remainder not below anchor count");

	a_last_range: assert property (@(posedge clk) disable iff (!arst_n)
		back_st.last_ok)
		else $error("last anchor index beyond anchor count");

	// a new pixel only appears when the slot was free or being drained
	a_out_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pixel_x) && $stable(last_pixel))
		else $error("stalled pixel overwritten");

endmodule
`default_nettype wire
